FILE: rtl/first_fit_block_allocator_core_assert.svh
// assertion macros for the first-fit allocator rtl
// no dependencies; compiles to nothing when SYNTHESIS is defined
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication under an active-low reset
`define FFBA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("ffba same-cycle check failed");
// next-cycle implication under an active-low reset
`define FFBA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("ffba next-cycle check failed");
`else
`define FFBA_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define FFBA_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

FILE: rtl/ffba_pkg.sv
// shared types, constants and helpers of the first-fit allocator
// no dependencies
package ffba_pkg;

	// default arena geometry in bytes
	localparam int DEF_ARENA_BYTES        = 4096;
	localparam int DEF_HEADER_BYTES       = 32;
	localparam int DEF_ARENA_HEADER_BYTES = 16;
	localparam int DEF_MIN_SPLIT_PAYLOAD  = 8;

	// payload field widths
	localparam int SIZE_W   = 12;
	localparam int OFFSET_W = 12;

	// allocation granule
	localparam int ALIGN_BYTES = 8;
	localparam int ALIGN_SHIFT = 3;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_OOM  = 2'd1,
		STATUS_ZERO = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_SPLIT,
		ST_MERGE,
		ST_DONE
	} fsm_state_t;

	// round a request up to the allocation granule
	function automatic logic [SIZE_W:0] round_up_granule(input logic [SIZE_W-1:0] n);
		logic [SIZE_W:0] s;
		s = {1'b0, n} + (SIZE_W + 1)'(ALIGN_BYTES - 1);
		return s & ~((SIZE_W + 1)'(ALIGN_BYTES - 1));
	endfunction

endpackage

FILE: rtl/ffba_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/first_fit_block_allocator_core.sv
// First-fit block allocator over a fixed arena of address-ordered blocks.
// Input channel s_*: one transaction is an allocate (tuser 0, request size)
// or a release (tuser 1, payload offset). Output channel m_*: exactly one
// result transaction per input, with status in tuser and granted offset.
// Block headers (free mark, payload size) live in a ram indexed by block
// start / 8; the next block starts right after the payload, so a walk reads
// one header per cycle through the single read port.
// An item walks k blocks in address order, then a split or a merge write
// follows where needed; k is at most about 102 at the default geometry.
// Zero-size requests and null releases skip the walk.
// One item is in work at a time; s_tready is high only while idle.
// The result sits in an output register, so a new item is accepted while
// a result waits; if the receiver stalls, the finished result of the next
// item waits until that register is free.
// Reset: one free block spans the arena; its header is supplied by a single
// valid flag until first written, so no clearing pass is needed.
// header file: first_fit_block_allocator_core_assert.svh; package: ffba_pkg
`include "first_fit_block_allocator_core_assert.svh"

module first_fit_block_allocator_core #(
	parameter int ARENA_BYTES        = ffba_pkg::DEF_ARENA_BYTES,
	parameter int HEADER_BYTES       = ffba_pkg::DEF_HEADER_BYTES,
	parameter int ARENA_HEADER_BYTES = ffba_pkg::DEF_ARENA_HEADER_BYTES,
	parameter int MIN_SPLIT_PAYLOAD  = ffba_pkg::DEF_MIN_SPLIT_PAYLOAD
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [11:0] request_size, [23:12] payload_offset
	input  logic [0:0]  s_tuser,   // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [11:0] granted_offset, [15:12] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int OW        = $clog2(ARENA_BYTES) + 1;
	localparam int NEED_W    = ffba_pkg::SIZE_W + 1;
	localparam int SW        = (OW > NEED_W) ? OW : NEED_W;
	localparam int DEPTH     = (ARENA_BYTES + ffba_pkg::ALIGN_BYTES - 1) / ffba_pkg::ALIGN_BYTES;
	localparam int IW        = $clog2(DEPTH);
	localparam int HW        = OW + 1;
	localparam int USED      = ARENA_HEADER_BYTES + HEADER_BYTES;
	localparam int INIT_SIZE = (ARENA_BYTES > USED) ? ARENA_BYTES - USED : 0;

	localparam logic [IW-1:0] FIRST_IDX    = IW'(ARENA_HEADER_BYTES / ffba_pkg::ALIGN_BYTES);
	localparam logic [SW-1:0] FIRST_START  = SW'(ARENA_HEADER_BYTES);
	localparam logic [SW-1:0] HDR_SW       = SW'(HEADER_BYTES);
	localparam logic [SW-1:0] ARENA_SW     = SW'(ARENA_BYTES);
	localparam logic [SW-1:0] SPLIT_MIN_SW = SW'(HEADER_BYTES + MIN_SPLIT_PAYLOAD);
	localparam logic [HW-1:0] INIT_HDR     = {1'b1, OW'(INIT_SIZE)};

	function automatic logic [IW-1:0] idx_of(input logic [SW-1:0] a);
		return IW'(a >> ffba_pkg::ALIGN_SHIFT);
	endfunction

	// control state
	ffba_pkg::fsm_state_t state_q, state_d;
	logic                 init_q, prev_valid_q, prev_valid_d, has_next_q, has_next_d;
	logic                 m_tvalid_q;

	// payload registers
	ffba_pkg::op_t               op_q, op_d;
	ffba_pkg::status_t           res_status_q, res_status_d;
	logic [ffba_pkg::OFFSET_W-1:0] res_offset_q, res_offset_d, off_q, off_d;
	logic [NEED_W-1:0]           need_q, need_d;
	logic [SW-1:0]               cur_start_q, cur_start_d, cur_size_q, cur_size_d;
	logic [SW-1:0]               prev_start_q, prev_start_d, prev_size_q, prev_size_d;
	logic                        prev_free_q, prev_free_d;
	logic [SW-1:0]               split_start_q, split_start_d, split_size_q, split_size_d;
	logic [IW-1:0]               rd_idx_q;
	logic [15:0]                 m_tdata_q;
	logic [1:0]                  m_tuser_q;

	// ram ports
	logic          wr_en, rd_en;
	logic [IW-1:0] wr_addr, rd_addr;
	logic [HW-1:0] wr_data, rd_data;

	// header decode and walk arithmetic
	ffba_pkg::op_t                 op_in;
	logic [ffba_pkg::SIZE_W-1:0]   req_in;
	logic [ffba_pkg::OFFSET_W-1:0] off_in;
	logic [HW-1:0]                 hdr_word;
	logic                          hdr_free, fits, at_end, load_out;
	logic [SW-1:0]                 hdr_size, next_start, payload_at, rest, merged;

	ffba_ram #(
		.WIDTH(HW),
		.DEPTH(DEPTH)
	) u_hdr_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// unpack the input transaction
	assign op_in  = ffba_pkg::op_t'(s_tuser[0]);
	assign req_in = s_tdata[11:0];
	assign off_in = s_tdata[23:12];

	// first block header reads as its reset value until written
	assign hdr_word   = (rd_idx_q == FIRST_IDX && !init_q) ? INIT_HDR : rd_data;
	assign hdr_free   = hdr_word[OW];
	assign hdr_size   = SW'(hdr_word[OW-1:0]);
	assign payload_at = cur_start_q + HDR_SW;
	assign next_start = payload_at + hdr_size;
	assign at_end     = next_start >= ARENA_SW;
	assign fits       = hdr_free && (hdr_size >= SW'(need_q));
	assign rest       = hdr_size - SW'(need_q);
	assign merged     = cur_size_q + ((has_next_q && hdr_free) ? hdr_size + HDR_SW : '0);
	assign load_out   = !m_tvalid_q || m_tready;

	assign s_tready = (state_q == ffba_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// next state, walk control and ram access
	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		need_d        = need_q;
		off_d         = off_q;
		cur_start_d   = cur_start_q;
		cur_size_d    = cur_size_q;
		prev_valid_d  = prev_valid_q;
		prev_start_d  = prev_start_q;
		prev_size_d   = prev_size_q;
		prev_free_d   = prev_free_q;
		has_next_d    = has_next_q;
		split_start_d = split_start_q;
		split_size_d  = split_size_q;
		res_status_d  = res_status_q;
		res_offset_d  = res_offset_q;
		rd_en         = 1'b0;
		rd_addr       = idx_of(next_start);
		wr_en         = 1'b0;
		wr_addr       = idx_of(cur_start_q);
		wr_data       = '0;
		case (state_q)
			ffba_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					op_d         = op_in;
					need_d       = ffba_pkg::round_up_granule(req_in);
					off_d        = off_in;
					res_offset_d = '0;
					if (op_in == ffba_pkg::OP_ALLOC && req_in == '0) begin
						res_status_d = ffba_pkg::STATUS_ZERO;
						state_d      = ffba_pkg::ST_DONE;
					end else if (op_in == ffba_pkg::OP_RELEASE && off_in == '0) begin
						res_status_d = ffba_pkg::STATUS_OK;
						state_d      = ffba_pkg::ST_DONE;
					end else begin
						rd_en        = 1'b1;
						rd_addr      = FIRST_IDX;
						cur_start_d  = FIRST_START;
						prev_valid_d = 1'b0;
						state_d      = ffba_pkg::ST_WALK;
					end
				end
			end
			ffba_pkg::ST_WALK: begin
				if (op_q == ffba_pkg::OP_ALLOC) begin
					if (fits) begin
						// take this block, split off the tail if it is large enough
						wr_en        = 1'b1;
						wr_data      = {1'b0, OW'(hdr_size)};
						res_status_d = ffba_pkg::STATUS_OK;
						res_offset_d = payload_at[ffba_pkg::OFFSET_W-1:0];
						state_d      = ffba_pkg::ST_DONE;
						if (rest >= SPLIT_MIN_SW) begin
							wr_data       = {1'b0, OW'(need_q)};
							split_start_d = payload_at + SW'(need_q);
							split_size_d  = rest - HDR_SW;
							state_d       = ffba_pkg::ST_SPLIT;
						end
					end else if (at_end) begin
						res_status_d = ffba_pkg::STATUS_OOM;
						res_offset_d = '0;
						state_d      = ffba_pkg::ST_DONE;
					end else begin
						rd_en       = 1'b1;
						cur_start_d = next_start;
					end
				end else begin
					res_status_d = ffba_pkg::STATUS_OK;
					res_offset_d = '0;
					if (payload_at == SW'(off_q)) begin
						// found: fetch the next header for the merge
						cur_size_d = hdr_size;
						has_next_d = !at_end;
						rd_en      = !at_end;
						state_d    = ffba_pkg::ST_MERGE;
					end else if (at_end) begin
						state_d = ffba_pkg::ST_DONE;
					end else begin
						prev_valid_d = 1'b1;
						prev_start_d = cur_start_q;
						prev_size_d  = hdr_size;
						prev_free_d  = hdr_free;
						rd_en        = 1'b1;
						cur_start_d  = next_start;
					end
				end
			end
			ffba_pkg::ST_SPLIT: begin
				wr_en   = 1'b1;
				wr_addr = idx_of(split_start_q);
				wr_data = {1'b1, OW'(split_size_q)};
				state_d = ffba_pkg::ST_DONE;
			end
			ffba_pkg::ST_MERGE: begin
				// absorb a free next block, then fold into a free previous one
				wr_en = 1'b1;
				if (prev_valid_q && prev_free_q) begin
					wr_addr = idx_of(prev_start_q);
					wr_data = {1'b1, OW'(prev_size_q + merged + HDR_SW)};
				end else begin
					wr_data = {1'b1, OW'(merged)};
				end
				state_d = ffba_pkg::ST_DONE;
			end
			ffba_pkg::ST_DONE: begin
				if (load_out) begin
					state_d = ffba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ffba_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ffba_pkg::ST_IDLE;
			init_q       <= 1'b0;
			prev_valid_q <= 1'b0;
			has_next_q   <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			prev_valid_q <= prev_valid_d;
			has_next_q   <= has_next_d;
			if (wr_en && wr_addr == FIRST_IDX) begin
				init_q <= 1'b1;
			end
			if (state_q == ffba_pkg::ST_DONE && load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		op_q          <= op_d;
		need_q        <= need_d;
		off_q         <= off_d;
		cur_start_q   <= cur_start_d;
		cur_size_q    <= cur_size_d;
		prev_start_q  <= prev_start_d;
		prev_size_q   <= prev_size_d;
		prev_free_q   <= prev_free_d;
		split_start_q <= split_start_d;
		split_size_q  <= split_size_d;
		res_status_q  <= res_status_d;
		res_offset_q  <= res_offset_d;
		if (rd_en) begin
			rd_idx_q <= rd_addr;
		end
		if (state_q == ffba_pkg::ST_DONE && load_out) begin
			m_tdata_q <= 16'(res_offset_q);
			m_tuser_q <= res_status_q;
		end
	end

	// checks
	`FFBA_ASSERT_IMP(a_walk_in_arena, clk, arst_n, state_q == ffba_pkg::ST_WALK, cur_start_q < ARENA_SW)
	`FFBA_ASSERT_NXT(a_one_item_in_work, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`FFBA_ASSERT_IMP(a_no_grant_on_fail, clk, arst_n, m_tvalid && m_tuser != ffba_pkg::STATUS_OK, m_tdata == 16'd0)
	`FFBA_ASSERT_IMP(a_status_code, clk, arst_n, m_tvalid, m_tuser != 2'd3)

endmodule
